// ===== design/assert_macros.svh =====
// Assertion macros shared by the Intel HEX encoder modules.
// Depends on nothing; the using module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, disabled while reset is low
`define IHX_ASSERT_CLK(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Check a property on the module's own clk and rst_n
`define IHX_ASSERT(lbl, prop, msg) \
    `IHX_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

// ===== design/ihex_pkg.sv =====
// Shared types, character codes and helpers for the Intel HEX encoder.
// Used by ihex_front, ihex_cmd_fifo, ihex_back and the top level.
package ihex_pkg;

    // Character codes
    localparam logic [6:0] CH_COLON = 7'h3A;
    localparam logic [6:0] CH_NL    = 7'h0A;

    // Record type and fixed field bytes
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_EXT  = 8'h04;
    localparam logic [7:0] EXT_LEN  = 8'h02;
    localparam logic [7:0] EOF_CK   = 8'hFF;
    localparam logic [7:0] ZERO_B   = 8'h00;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LEN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_ADDR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_EXTENDED = 2'd3;

    // Record pieces walked by the back end, in emission order
    typedef enum logic [2:0] {
        PH_EXT,
        PH_HDR,
        PH_DATA,
        PH_CKS,
        PH_EOF
    } phase_t;

    // One classified input byte: everything the back end needs to print it
    typedef struct packed {
        logic        ext;     // extended linear address record first
        logic [15:0] up;      // upper address half for that record
        logic [7:0]  ext_ck;  // its checksum
        logic        hdr;     // data record header first
        logic [7:0]  len;     // record length
        logic [15:0] lo;      // record load offset
        logic [7:0]  data;    // the raw byte
        logic        cks;     // record closes after this byte
        logic [7:0]  sum_ck;  // closing checksum
        logic        eof;     // end-of-file record follows
    } ihex_cmd_t;

    // Uppercase ASCII hex digit of a nibble
    function automatic logic [6:0] hex_ascii(input logic [3:0] v);
        logic [6:0] r;
        if (v < 4'd10)
            r = 7'h30 + {3'd0, v};
        else
            r = 7'h41 + {3'd0, v - 4'd10};
        return r;
    endfunction

endpackage

// ===== design/ihex_front.sv =====
// Front end of the Intel HEX encoder: configuration registers, image and
// record bookkeeping, classification of each byte. Depends on ihex_pkg.
`include "assert_macros.svh"

module ihex_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ihex_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           push,
    input  logic [7:0]                     data_byte,
    input  logic                           q_full,
    output logic                           cmd_push,
    output ihex_pkg::ihex_cmd_t            cmd
);

    localparam logic [7:0] EXT_SUM = ihex_pkg::EXT_LEN + ihex_pkg::REC_EXT;

    // Configuration registers
    logic [7:0]  bpl_reg;
    logic [31:0] start_addr_reg;
    logic [31:0] total_len_reg;
    logic        use_ext_reg;

    // Image state
    logic [31:0] next_addr_reg, next_addr_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  rec_left_reg, rec_left_next;
    logic [7:0]  run_sum_reg, run_sum_next;
    logic [15:0] upper_reg, upper_next;
    logic        upper_valid_reg, upper_valid_next;

    logic        img_start;
    logic [31:0] addr;
    logic [31:0] left;
    logic [7:0]  rec_left;
    logic        uv;
    logic        rec_start;
    logic [15:0] up;
    logic [15:0] lo;
    logic        ext;
    logic [7:0]  bpl_eff;
    logic [7:0]  len_a;
    logic [16:0] to_bound;
    logic [7:0]  len;
    logic [7:0]  sum_base;
    logic [7:0]  sum_new;
    logic [7:0]  rl_after;
    logic [31:0] left_after;

    assign cfg_ready = 1'b1;
    assign cmd_push  = push && !q_full;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpl_reg        <= 8'd16;
            start_addr_reg <= 32'd0;
            total_len_reg  <= 32'd1;
            use_ext_reg    <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ihex_pkg::CFG_LINE_LEN:     bpl_reg        <= cfg_data[7:0];
                ihex_pkg::CFG_LOAD_ADDR:    start_addr_reg <= cfg_data;
                ihex_pkg::CFG_TOTAL_LENGTH: total_len_reg  <= cfg_data;
                ihex_pkg::CFG_USE_EXTENDED: use_ext_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Load image state at image start, pick record length at record start
    always_comb
    begin
        img_start = (bytes_left_reg == 32'd0);
        addr      = img_start ? start_addr_reg : next_addr_reg;
        if (img_start)
            left = (total_len_reg == 32'd0) ? 32'd1 : total_len_reg;
        else
            left = bytes_left_reg;
        rec_left  = img_start ? 8'd0 : rec_left_reg;
        uv        = img_start ? 1'b0 : upper_valid_reg;
        rec_start = (rec_left == 8'd0);
        up        = addr[31:16];
        lo        = addr[15:0];
        ext       = rec_start && use_ext_reg && (!uv || (upper_reg != up));

        bpl_eff  = (bpl_reg == 8'd0) ? 8'd1 : bpl_reg;
        len_a    = (left < {24'd0, bpl_eff}) ? left[7:0] : bpl_eff;
        to_bound = 17'h10000 - {1'b0, lo};
        len      = ({9'd0, len_a} > to_bound) ? to_bound[7:0] : len_a;

        sum_base   = rec_start ? (len + lo[15:8] + lo[7:0]) : run_sum_reg;
        sum_new    = sum_base + data_byte;
        rl_after   = (rec_start ? len : rec_left) - 8'd1;
        left_after = left - 32'd1;

        cmd.ext    = ext;
        cmd.up     = up;
        cmd.ext_ck = 8'd0 - (EXT_SUM + up[15:8] + up[7:0]);
        cmd.hdr    = rec_start;
        cmd.len    = len;
        cmd.lo     = lo;
        cmd.data   = data_byte;
        cmd.cks    = (rl_after == 8'd0);
        cmd.sum_ck = 8'd0 - sum_new;
        cmd.eof    = (left_after == 32'd0);

        next_addr_next   = next_addr_reg;
        bytes_left_next  = bytes_left_reg;
        rec_left_next    = rec_left_reg;
        run_sum_next     = run_sum_reg;
        upper_next       = upper_reg;
        upper_valid_next = upper_valid_reg;
        if (cmd_push)
        begin
            next_addr_next   = addr + 32'd1;
            bytes_left_next  = left_after;
            rec_left_next    = cmd.eof ? 8'd0 : rl_after;
            run_sum_next     = sum_new;
            upper_next       = ext ? up : upper_reg;
            upper_valid_next = ext ? 1'b1 : uv;
        end
    end

    // Advance image state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_addr_reg   <= 32'd0;
            bytes_left_reg  <= 32'd0;
            rec_left_reg    <= 8'd0;
            run_sum_reg     <= 8'd0;
            upper_reg       <= 16'd0;
            upper_valid_reg <= 1'b0;
        end
        else
        begin
            next_addr_reg   <= next_addr_next;
            bytes_left_reg  <= bytes_left_next;
            rec_left_reg    <= rec_left_next;
            run_sum_reg     <= run_sum_next;
            upper_reg       <= upper_next;
            upper_valid_reg <= upper_valid_next;
        end
    end

    `IHX_ASSERT(a_ext_has_hdr, cmd_push && cmd.ext |-> cmd.hdr, "extended record without header")
    `IHX_ASSERT(a_len_range, cmd_push && cmd.hdr |-> (cmd.len != 8'd0) && (cmd.len <= bpl_eff), "record length out of range")
    `IHX_ASSERT(a_eof_idle, cmd_push && cmd.eof |=> (bytes_left_reg == 32'd0) && (rec_left_reg == 8'd0), "image not closed after end of file")

endmodule

// ===== design/ihex_cmd_fifo.sv =====
// Short queue of classified bytes between front and back end.
// Depends on ihex_pkg for the entry type.
module ihex_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  ihex_pkg::ihex_cmd_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output logic                rd_valid,
    output ihex_pkg::ihex_cmd_t rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    ihex_pkg::ihex_cmd_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Step pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (!wr_en && rd_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== design/ihex_back.sv =====
// Back end of the Intel HEX encoder: walks each queued byte's record pieces
// one character per cycle, while not stalled by pop, into the output register. Depends on ihex_pkg.
`include "assert_macros.svh"

module ihex_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  ihex_pkg::ihex_cmd_t cmd,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output logic [6:0]          ascii_char,
    output logic                last_of_run,
    output logic                file_done
);

    localparam logic [3:0] EXT_LAST  = 4'd15;
    localparam logic [3:0] HDR_LAST  = 4'd8;
    localparam logic [3:0] DATA_LAST = 4'd1;
    localparam logic [3:0] CKS_LAST  = 4'd2;
    localparam logic [3:0] EOF_LAST  = 4'd11;

    ihex_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       idx_reg, idx_next;
    logic             started_reg, started_next;
    logic             out_valid_reg, out_valid_next;
    logic [6:0]       char_reg;
    logic             last_reg;
    logic             done_reg;

    ihex_pkg::phase_t ph;
    logic [3:0]       idx;
    logic [3:0]       k;
    logic [3:0]       last_idx;
    logic             out_load;
    logic             at_last;
    logic [7:0]       sel_byte;
    logic             is_colon;
    logic             is_nl;
    logic [6:0]       ch;
    logic             ch_last;
    logic             ch_done;

    assign empty       = !out_valid_reg;
    assign ascii_char  = char_reg;
    assign last_of_run = last_reg;
    assign file_done   = done_reg;

    // Pick the character at the current piece and position
    always_comb
    begin
        if (started_reg)
            ph = phase_reg;
        else if (cmd.ext)
            ph = ihex_pkg::PH_EXT;
        else if (cmd.hdr)
            ph = ihex_pkg::PH_HDR;
        else
            ph = ihex_pkg::PH_DATA;
        idx = started_reg ? idx_reg : 4'd0;
        k   = idx - 4'd1;

        is_colon = 1'b0;
        is_nl    = 1'b0;
        sel_byte = ihex_pkg::ZERO_B;
        last_idx = DATA_LAST;
        unique case (ph)
            ihex_pkg::PH_EXT:
            begin
                last_idx = EXT_LAST;
                is_colon = (idx == 4'd0);
                is_nl    = (idx == EXT_LAST);
                case (k[3:1])
                    3'd0:    sel_byte = ihex_pkg::EXT_LEN;
                    3'd3:    sel_byte = ihex_pkg::REC_EXT;
                    3'd4:    sel_byte = cmd.up[15:8];
                    3'd5:    sel_byte = cmd.up[7:0];
                    3'd6:    sel_byte = cmd.ext_ck;
                    default: sel_byte = ihex_pkg::ZERO_B;
                endcase
            end
            ihex_pkg::PH_HDR:
            begin
                last_idx = HDR_LAST;
                is_colon = (idx == 4'd0);
                case (k[2:1])
                    2'd0:    sel_byte = cmd.len;
                    2'd1:    sel_byte = cmd.lo[15:8];
                    2'd2:    sel_byte = cmd.lo[7:0];
                    default: sel_byte = ihex_pkg::REC_DATA;
                endcase
            end
            ihex_pkg::PH_DATA:
            begin
                last_idx = DATA_LAST;
                sel_byte = cmd.data;
            end
            ihex_pkg::PH_CKS:
            begin
                last_idx = CKS_LAST;
                is_nl    = (idx == CKS_LAST);
                sel_byte = cmd.sum_ck;
            end
            ihex_pkg::PH_EOF:
            begin
                last_idx = EOF_LAST;
                is_colon = (idx == 4'd0);
                is_nl    = (idx == EOF_LAST);
                case (k[3:1])
                    3'd3:    sel_byte = ihex_pkg::REC_EOF;
                    3'd4:    sel_byte = ihex_pkg::EOF_CK;
                    default: sel_byte = ihex_pkg::ZERO_B;
                endcase
            end
            default: ;
        endcase

        // Digits after a colon start at odd positions, else at even ones
        if (is_colon)
            ch = ihex_pkg::CH_COLON;
        else if (is_nl)
            ch = ihex_pkg::CH_NL;
        else if ((ph == ihex_pkg::PH_DATA) || (ph == ihex_pkg::PH_CKS))
            ch = ihex_pkg::hex_ascii(idx[0] ? sel_byte[3:0] : sel_byte[7:4]);
        else
            ch = ihex_pkg::hex_ascii(k[0] ? sel_byte[3:0] : sel_byte[7:4]);

        at_last = (idx == last_idx);
        ch_done = (ph == ihex_pkg::PH_EOF) && at_last;
        ch_last = at_last &&
                  (ch_done || ((ph == ihex_pkg::PH_CKS) && !cmd.eof) ||
                   ((ph == ihex_pkg::PH_DATA) && !cmd.cks && !cmd.eof));
    end

    // Advance through the pieces when the output register can take a beat
    always_comb
    begin
        out_load       = cmd_valid && (!out_valid_reg || pop);
        cmd_pop        = out_load && ch_last;
        out_valid_next = out_load || (out_valid_reg && !pop);
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        started_next   = started_reg;
        if (out_load)
        begin
            if (ch_last)
            begin
                started_next = 1'b0;
                idx_next     = 4'd0;
            end
            else if (at_last)
            begin
                started_next = 1'b1;
                idx_next     = 4'd0;
                unique case (ph)
                    ihex_pkg::PH_EXT:  phase_next = ihex_pkg::PH_HDR;
                    ihex_pkg::PH_HDR:  phase_next = ihex_pkg::PH_DATA;
                    ihex_pkg::PH_DATA:
                        phase_next = cmd.cks ? ihex_pkg::PH_CKS : ihex_pkg::PH_EOF;
                    default:           phase_next = ihex_pkg::PH_EOF;
                endcase
            end
            else
            begin
                started_next = 1'b1;
                phase_next   = ph;
                idx_next     = idx + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ihex_pkg::PH_DATA;
            idx_reg       <= 4'd0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output beat
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            char_reg <= ch;
            last_reg <= ch_last;
            done_reg <= ch_done;
        end
    end

    `IHX_ASSERT(a_done_is_nl, out_valid_reg && done_reg |-> (char_reg == ihex_pkg::CH_NL) && last_reg, "file done not on closing newline")
    `IHX_ASSERT(a_started_has_cmd, started_reg |-> cmd_valid, "mid-record with no queued byte")
    `IHX_ASSERT(a_pop_on_last, cmd_pop |=> out_valid_reg && last_reg, "queued byte dropped before its last beat")

endmodule

// ===== design/intel_hex_record_encoder.sv =====
// Intel HEX record encoder: one binary byte in, hex text out a beat per char.
// An accepted byte goes into the command queue, then its first character into
// the output register. One output character per cycle while pop keeps up and
// bytes wait: two hex digits per data byte, plus record and file framing.
// Reset: asynchronous, active low; registers take 16, 0, 1, 1, block is idle.
module intel_hex_record_encoder #(
    parameter int CMD_DEPTH = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ihex_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     data_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [6:0]                     ascii_char,
    output logic                           last_of_run,
    output logic                           file_done
);

    ihex_pkg::ihex_cmd_t wr_cmd;
    ihex_pkg::ihex_cmd_t rd_cmd;
    logic                cmd_push;
    logic                cmd_pop;
    logic                cmd_valid;

    // Classify bytes
    ihex_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .data_byte (data_byte),
        .q_full    (full),
        .cmd_push  (cmd_push),
        .cmd       (wr_cmd)
    );

    // Decouple front and back
    ihex_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (wr_cmd),
        .full     (full),
        .rd_en    (cmd_pop),
        .rd_valid (cmd_valid),
        .rd_data  (rd_cmd)
    );

    // Print characters
    ihex_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (rd_cmd),
        .cmd_pop     (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .ascii_char  (ascii_char),
        .last_of_run (last_of_run),
        .file_done   (file_done)
    );

endmodule
